[src/assert_macros.svh]
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/rgb_led_pkg.sv]
// types, codes and color helpers for the rgb lamp controller
`timescale 1ns / 1ps

package rgb_led_pkg;

    localparam logic [7:0] FULL_LEVEL  = 8'd255;
    localparam logic [2:0] PHASE_COUNT = 3'd6;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_ON     = 2'd1,
        ACT_OFF    = 2'd2,
        ACT_TOGGLE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2,
        SEL_SPARE = 2'd3
    } t_sel;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [1:0] action;
        logic       color_button_level;
        logic       off_button_level;
        logic       rainbow_button_level;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic       rainbow_active;
        logic       lamp_off;
    } t_out_beat;

    localparam t_rgb RGB_BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};
    localparam t_rgb RGB_RED   = '{red: FULL_LEVEL, green: 8'd0, blue: 8'd0};

    // fixed color for a selector code, spare code shows red
    function automatic t_rgb color_of(input t_sel sel);
        t_rgb c;
        c = RGB_RED;
        case (sel)
            SEL_GREEN: c = '{red: 8'd0, green: FULL_LEVEL, blue: 8'd0};
            SEL_BLUE:  c = '{red: 8'd0, green: 8'd0, blue: FULL_LEVEL};
            default:   c = RGB_RED;
        endcase
        return c;
    endfunction

    // next selector, wraps blue back to red, spare code steps to green
    function automatic t_sel next_sel(input t_sel sel);
        t_sel n;
        n = SEL_GREEN;
        case (sel)
            SEL_RED:   n = SEL_GREEN;
            SEL_GREEN: n = SEL_BLUE;
            SEL_BLUE:  n = SEL_RED;
            default:   n = SEL_GREEN;
        endcase
        return n;
    endfunction

    // color wheel point for a phase and step
    function automatic t_rgb sweep_point(input logic [2:0] phase, input logic [7:0] step);
        t_rgb c;
        c = RGB_RED;
        case (phase)
            3'd0:    c = '{red: FULL_LEVEL, green: step, blue: 8'd0};
            3'd1:    c = '{red: FULL_LEVEL - step, green: FULL_LEVEL, blue: 8'd0};
            3'd2:    c = '{red: 8'd0, green: FULL_LEVEL, blue: step};
            3'd3:    c = '{red: 8'd0, green: FULL_LEVEL - step, blue: FULL_LEVEL};
            3'd4:    c = '{red: step, green: 8'd0, blue: FULL_LEVEL};
            3'd5:    c = '{red: FULL_LEVEL, green: 8'd0, blue: FULL_LEVEL - step};
            default: c = RGB_RED;
        endcase
        return c;
    endfunction

endpackage

[src/rgb_led_button_mode_controller.sv]
// top level of the rgb lamp controller: buttons, remote power and color wheel
//
//  channel | direction | handshake                  | payload
//  in      | into      | i_in_valid / o_in_stall    | i_in_data  (t_in_beat)
//  out     | out of    | o_out_valid / i_out_stall  | o_out_data (t_out_beat)
//
// every in beat gives exactly one out beat, offered from the result register
// one beat per cycle unless out stalls: input register, lamp logic, result register
// the lamp state updates in the same cycle the result register loads
// reset (i_rst_n low, synchronous) gives red, no rainbow, buttons released
// a stalled out beat holds the pipe; in is stalled only while the input register is full
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rgb_led_button_mode_controller (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  rgb_led_pkg::t_in_beat  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output rgb_led_pkg::t_out_beat o_out_data
);
    import rgb_led_pkg::*;

    // pipe registers
    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;

    // lamp state
    t_rgb       r_shown,   n_shown;
    t_sel       r_sel,     n_sel;
    logic       r_off,     n_off;
    logic       r_rainbow, n_rainbow;
    logic [2:0] r_last,    n_last;
    logic [2:0] r_phase,   n_phase;
    logic [7:0] r_step,    n_step;

    logic       advance;
    logic       in_take;
    logic [2:0] levels;
    logic [2:0] falling;
    logic [7:0] step_inc;

    // result register moves when a beat waits and the result register is empty or being drained
    assign advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take  = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !advance;

    // pin levels, color in bit 0, off in bit 1, rainbow in bit 2
    assign levels   = {r_in.rainbow_button_level, r_in.off_button_level,
                       r_in.color_button_level};
    assign falling  = r_last & ~levels;
    assign step_inc = r_step + 8'd1;

    always_comb begin
        n_shown   = r_shown;
        n_sel     = r_sel;
        n_off     = r_off;
        n_rainbow = r_rainbow;
        n_last    = r_last;
        n_phase   = r_phase;
        n_step    = r_step;

        case (t_action'(r_in.action))
            ACT_TICK: begin
                // color button: step selector, leave rainbow and off
                if (falling[0]) begin
                    n_sel     = next_sel(r_sel);
                    n_rainbow = 1'b0;
                    n_off     = 1'b0;
                    n_shown   = color_of(next_sel(r_sel));
                end
                // off button: toggle dark against selected color
                if (falling[1]) begin
                    n_rainbow = 1'b0;
                    n_off     = !n_off;
                    n_shown   = n_off ? RGB_BLACK : color_of(n_sel);
                end
                // rainbow button: toggle sweep
                if (falling[2]) begin
                    n_rainbow = !n_rainbow;
                    if (!n_rainbow) begin
                        n_shown = color_of(n_sel);
                    end
                end
                n_last = levels;

                // sweep restarts on a fresh start or an out-of-range phase, else steps once per tick
                if (n_rainbow) begin
                    if (!r_rainbow) begin
                        n_phase = 3'd0;
                        n_step  = 8'd0;
                    end else if (r_phase >= PHASE_COUNT) begin
                        n_phase = 3'd0;
                        n_step  = 8'd0;
                    end else if (step_inc == FULL_LEVEL) begin
                        n_step  = 8'd0;
                        n_phase = (r_phase == PHASE_COUNT - 3'd1) ? 3'd0 : r_phase + 3'd1;
                    end else begin
                        n_step  = step_inc;
                    end
                    n_shown = sweep_point(n_phase, n_step);
                end
            end
            ACT_ON: begin
                if (!r_rainbow) begin
                    n_shown = color_of(r_sel);
                end
            end
            ACT_OFF: begin
                if (!r_rainbow) begin
                    n_shown = RGB_BLACK;
                end
            end
            default: begin
                // remote toggle acts like the off button, but only while no sweep runs
                if (!r_rainbow) begin
                    n_off   = !r_off;
                    n_shown = r_off ? color_of(r_sel) : RGB_BLACK;
                end
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // lamp state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_shown     <= RGB_RED;
            r_sel       <= SEL_RED;
            r_off       <= 1'b0;
            r_rainbow   <= 1'b0;
            r_last      <= 3'b111;
            r_phase     <= 3'd0;
            r_step      <= 8'd0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_shown     <= n_shown;
                r_sel       <= n_sel;
                r_off       <= n_off;
                r_rainbow   <= n_rainbow;
                r_last      <= n_last;
                r_phase     <= n_phase;
                r_step      <= n_step;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out <= '{red_level: n_shown.red, green_level: n_shown.green,
                       blue_level: n_shown.blue, rainbow_active: n_rainbow,
                       lamp_off: n_off};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks on the lamp logic
    `ASSERT_IMPL(a_sel_used, 1'b1, r_sel != SEL_SPARE, "selector reached spare code")
    `ASSERT_IMPL(a_phase_range, 1'b1, r_phase < PHASE_COUNT, "sweep phase out of range")
    `ASSERT_IMPL(a_step_range, 1'b1, r_step != FULL_LEVEL, "sweep step reached full level")
    `ASSERT_IMPL(a_sweep_has_full, o_out_valid && o_out_data.rainbow_active,
        o_out_data.red_level == FULL_LEVEL || o_out_data.green_level == FULL_LEVEL ||
        o_out_data.blue_level == FULL_LEVEL, "sweep point lacks a full channel")
    `ASSERT_NEXT(a_no_lost_beat, r_in_valid && r_out_valid && i_out_stall,
        r_in_valid, "held input beat dropped under stall")

endmodule

[verif/rgb_led_button_mode_controller_test.sv]
// self-checking testbench for the rgb lamp controller: directed table, then random beats
`timescale 1ns / 1ps

module rgb_led_button_mode_controller_test;

    import rgb_led_pkg::*;

    localparam int     HALF_PERIOD  = 6;
    localparam int     RESET_CYCLES = 5;
    localparam int     RANDOM_BEATS = 360;
    // sweep through the first two phases and into the third
    localparam int     WHEEL_TICKS  = 520;
    // extra wait after the last result is checked, leave some slack
    localparam int     DRAIN_CYCLES = 8;
    localparam longint RUN_LIMIT_NS = 2_400_000;

    // sender runs with no gaps for this range of beats
    localparam int BURST_FIRST = 600;
    localparam int BURST_LAST  = 800;
    // receiver cycle windows: long hold-off, then a stretch with no stalls
    localparam int HOLD_FIRST  = 150;
    localparam int HOLD_LAST   = 230;
    localparam int OPEN_FIRST  = 400;
    localparam int OPEN_LAST   = 700;

    // pin levels as {rainbow, off, color}, active low
    localparam logic [2:0] LV_RELEASED = 3'b111;
    localparam logic [2:0] LV_COLOR    = 3'b110;
    localparam logic [2:0] LV_OFF      = 3'b101;
    localparam logic [2:0] LV_RAINBOW  = 3'b011;
    localparam logic [2:0] LV_ALL      = 3'b000;
    localparam logic [2:0] LV_COLOR_RB = 3'b010;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out_data;

    rgb_led_button_mode_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // lamp predictor: own copy of the controller state
    // ------------------------------------------------------------------
    t_rgb       lamp_rgb;
    t_sel       sel_q;
    bit         dark_q;
    bit         wheel_q;
    logic [2:0] pins_q;
    logic [2:0] wheel_phase;
    logic [7:0] wheel_step;

    // results still owed by the block, oldest first
    t_out_beat  lamp_q[$];
    int         sent_count;
    int         mismatch_count = 0;

    function automatic t_rgb fixed_color(input t_sel s);
        case (s)
            SEL_GREEN: return '{8'd0, FULL_LEVEL, 8'd0};
            SEL_BLUE:  return '{8'd0, 8'd0, FULL_LEVEL};
            default:   return RGB_RED;
        endcase
    endfunction

    // off button press, also what a remote toggle does
    function automatic void toggle_dark();
        wheel_q = 1'b0;
        if (!dark_q) begin
            dark_q   = 1'b1;
            lamp_rgb = RGB_BLACK;
        end else begin
            dark_q   = 1'b0;
            lamp_rgb = fixed_color(sel_q);
        end
    endfunction

    function automatic t_out_beat predict_lamp(input t_in_beat b);
        logic [2:0] pins;
        logic [2:0] fall;
        bit         was_wheel;
        pins      = {b.rainbow_button_level, b.off_button_level, b.color_button_level};
        fall      = pins_q & ~pins;
        was_wheel = wheel_q;
        case (t_action'(b.action))
            ACT_TICK: begin
                // buttons in order color, off, rainbow
                if (fall[0]) begin
                    case (sel_q)
                        SEL_GREEN: sel_q = SEL_BLUE;
                        SEL_BLUE:  sel_q = SEL_RED;
                        default:   sel_q = SEL_GREEN;
                    endcase
                    wheel_q  = 1'b0;
                    dark_q   = 1'b0;
                    lamp_rgb = fixed_color(sel_q);
                end
                if (fall[1])
                    toggle_dark();
                if (fall[2]) begin
                    wheel_q = !wheel_q;
                    if (!wheel_q)
                        lamp_rgb = fixed_color(sel_q);
                end
                pins_q = pins;
                // sweep restarts on a fresh start, else advances even if
                // the same tick ended and restarted it
                if (wheel_q) begin
                    if (!was_wheel) begin
                        wheel_phase = 3'd0;
                        wheel_step  = 8'd0;
                    end else if (wheel_step == FULL_LEVEL - 8'd1) begin
                        wheel_step  = 8'd0;
                        wheel_phase = (wheel_phase == PHASE_COUNT - 3'd1) ? 3'd0
                                                                         : wheel_phase + 3'd1;
                    end else begin
                        wheel_step = wheel_step + 8'd1;
                    end
                    case (wheel_phase)
                        3'd0:    lamp_rgb = '{FULL_LEVEL, wheel_step, 8'd0};
                        3'd1:    lamp_rgb = '{FULL_LEVEL - wheel_step, FULL_LEVEL, 8'd0};
                        3'd2:    lamp_rgb = '{8'd0, FULL_LEVEL, wheel_step};
                        3'd3:    lamp_rgb = '{8'd0, FULL_LEVEL - wheel_step, FULL_LEVEL};
                        3'd4:    lamp_rgb = '{wheel_step, 8'd0, FULL_LEVEL};
                        3'd5:    lamp_rgb = '{FULL_LEVEL, 8'd0, FULL_LEVEL - wheel_step};
                        default: lamp_rgb = RGB_RED;
                    endcase
                end
            end
            // remote power is ignored while the sweep runs
            ACT_ON:  if (!wheel_q) lamp_rgb = fixed_color(sel_q);
            ACT_OFF: if (!wheel_q) lamp_rgb = RGB_BLACK;
            default: if (!wheel_q) toggle_dark();
        endcase
        return '{red_level: lamp_rgb.red, green_level: lamp_rgb.green,
                 blue_level: lamp_rgb.blue, rainbow_active: wheel_q, lamp_off: dark_q};
    endfunction

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    typedef struct {
        t_in_beat  beat;
        bit        typed;
        t_out_beat want;
    } t_plan_row;

    t_plan_row plan[$];

    function automatic t_in_beat beat_of(input t_action a, input logic [2:0] pins);
        t_in_beat b;
        b.action               = a;
        b.color_button_level   = pins[0];
        b.off_button_level     = pins[1];
        b.rainbow_button_level = pins[2];
        return b;
    endfunction

    function automatic t_out_beat lamp_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] bl, input logic wheel,
                                          input logic dark);
        return '{red_level: r, green_level: g, blue_level: bl,
                 rainbow_active: wheel, lamp_off: dark};
    endfunction

    function automatic void add_row(input t_action a, input logic [2:0] pins,
                                    input bit typed, input t_out_beat want);
        plan.push_back('{beat: beat_of(a, pins), typed: typed, want: want});
    endfunction

    // ------------------------------------------------------------------
    // input side: one beat at a time, random gaps, prediction on accept
    // ------------------------------------------------------------------
    task automatic send_beat(input t_in_beat b, input bit typed, input t_out_beat want);
        t_out_beat predicted;
        if (sent_count < BURST_FIRST || sent_count >= BURST_LAST)
            while ($urandom_range(99) < 25) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        // accepted at this edge
        predicted = predict_lamp(b);
        lamp_q.push_back(typed ? want : predicted);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic send_plain(input t_action a, input logic [2:0] pins);
        send_beat(beat_of(a, pins), 1'b0, '0);
    endtask

    // get the sweep freshly started at full red, whatever the current mode
    task automatic start_wheel();
        send_plain(ACT_TICK, LV_RELEASED);
        if (wheel_q) begin
            send_plain(ACT_TICK, LV_RAINBOW);
            send_plain(ACT_TICK, LV_RELEASED);
        end
        send_plain(ACT_TICK, LV_RAINBOW);
    endtask

    initial begin : in_side
        int         pick;
        int         first_random;
        logic [2:0] pins;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        sent_count = 0;

        // predictor reset: full red, nothing pressed
        lamp_rgb    = RGB_RED;
        sel_q       = SEL_RED;
        dark_q      = 1'b0;
        wheel_q     = 1'b0;
        pins_q      = LV_RELEASED;
        wheel_phase = 3'd0;
        wheel_step  = 8'd0;

        // power commands from reset, then color stepping
        add_row(ACT_TICK,   LV_RELEASED, 1'b1, lamp_of(8'd255, 8'd0, 8'd0, 1'b0, 1'b0));
        add_row(ACT_ON,     LV_RELEASED, 1'b1, lamp_of(8'd255, 8'd0, 8'd0, 1'b0, 1'b0));
        add_row(ACT_OFF,    LV_RELEASED, 1'b1, lamp_of(8'd0,   8'd0, 8'd0, 1'b0, 1'b0));
        add_row(ACT_ON,     LV_RELEASED, 1'b1, lamp_of(8'd255, 8'd0, 8'd0, 1'b0, 1'b0));
        add_row(ACT_TOGGLE, LV_RELEASED, 1'b1, lamp_of(8'd0,   8'd0, 8'd0, 1'b0, 1'b1));
        add_row(ACT_TOGGLE, LV_RELEASED, 1'b1, lamp_of(8'd255, 8'd0, 8'd0, 1'b0, 1'b0));
        add_row(ACT_TICK,   LV_COLOR,    1'b1, lamp_of(8'd0, 8'd255, 8'd0, 1'b0, 1'b0));
        add_row(ACT_TICK,   LV_COLOR,    1'b0, '0);   // held, no edge
        add_row(ACT_TICK,   LV_RELEASED, 1'b0, '0);
        add_row(ACT_TICK,   LV_COLOR,    1'b0, '0);   // blue
        add_row(ACT_TICK,   LV_RELEASED, 1'b0, '0);
        add_row(ACT_TICK,   LV_COLOR,    1'b0, '0);   // wraps to red
        // off press, then rainbow started while dark
        add_row(ACT_TICK,   LV_OFF,      1'b1, lamp_of(8'd0,   8'd0, 8'd0, 1'b0, 1'b1));
        add_row(ACT_TICK,   LV_RAINBOW,  1'b1, lamp_of(8'd255, 8'd0, 8'd0, 1'b1, 1'b1));
        // remote power while the sweep runs is ignored
        add_row(ACT_TOGGLE, LV_RAINBOW,  1'b0, '0);
        add_row(ACT_ON,     LV_ALL,      1'b0, '0);
        add_row(ACT_OFF,    LV_RELEASED, 1'b0, '0);
        add_row(ACT_TICK,   LV_RELEASED, 1'b0, '0);   // first sweep step
        // rainbow ended by its own button: lit but still flagged off
        add_row(ACT_TICK,   LV_RAINBOW,  1'b1, lamp_of(8'd255, 8'd0, 8'd0, 1'b0, 1'b1));
        add_row(ACT_TICK,   LV_RELEASED, 1'b0, '0);
        add_row(ACT_TICK,   LV_RAINBOW,  1'b0, '0);
        // color and off on the same tick
        add_row(ACT_TICK,   LV_ALL,      1'b1, lamp_of(8'd0,   8'd0, 8'd0, 1'b0, 1'b1));
        add_row(ACT_TICK,   LV_RELEASED, 1'b0, '0);
        // all three on one tick: sweep restarts
        add_row(ACT_TICK,   LV_ALL,      1'b1, lamp_of(8'd255, 8'd0, 8'd0, 1'b1, 1'b1));
        add_row(ACT_TICK,   LV_RELEASED, 1'b0, '0);
        // color ends and rainbow restarts in one tick: sweep still advances
        add_row(ACT_TICK,   LV_COLOR_RB, 1'b0, '0);
        add_row(ACT_TICK,   LV_RELEASED, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k])
            send_beat(plan[k].beat, plan[k].typed, plan[k].want);

        // one uninterrupted sweep across the first phase boundaries
        start_wheel();
        repeat (WHEEL_TICKS) send_plain(ACT_TICK, LV_RELEASED);

        first_random = sent_count;
        while (sent_count - first_random < RANDOM_BEATS) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                // noise: anything at all
                repeat ($urandom_range(1, 8))
                    send_plain(t_action'($urandom_range(3)), 3'($urandom_range(7)));
            end else if (pick < 55) begin
                // press, maybe hold, release; remote power mixed in
                repeat ($urandom_range(1, 6)) begin
                    pins = 3'($urandom_range(6));
                    repeat ($urandom_range(1, 3)) send_plain(ACT_TICK, pins);
                    if ($urandom_range(3) == 0)
                        send_plain(t_action'($urandom_range(1, 3)), pins);
                    send_plain(ACT_TICK, LV_RELEASED);
                end
            end else if (pick < 80) begin
                // sweep run of random length, ended by one of the buttons
                start_wheel();
                repeat ($urandom_range(1, 300)) begin
                    if ($urandom_range(9) == 0)
                        send_plain(t_action'($urandom_range(1, 3)), 3'($urandom_range(7)));
                    else
                        send_plain(ACT_TICK, LV_RELEASED);
                end
                case ($urandom_range(2))
                    0:       pins = LV_RAINBOW;
                    1:       pins = LV_COLOR;
                    default: pins = LV_OFF;
                endcase
                send_plain(ACT_TICK, pins);
                send_plain(ACT_TICK, LV_RELEASED);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_plain(t_action'($urandom_range(1, 3)), LV_RELEASED);
            end
        end
        i_in_valid <= 1'b0;

        while (lamp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // output side: stall pattern with a long hold-off and an open stretch
    // ------------------------------------------------------------------
    initial begin : out_side
        int cyc;
        cyc = 0;
        i_out_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            // hold-off fills the pipe so the block must stall its input
            if (cyc >= HOLD_FIRST && cyc < HOLD_LAST)
                i_out_stall <= 1'b1;
            else if (cyc >= OPEN_FIRST && cyc < OPEN_LAST)
                i_out_stall <= 1'b0;
            else
                i_out_stall <= ($urandom_range(99) < 25);
        end
    end

    // ------------------------------------------------------------------
    // result check against the oldest pending result
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic [25:0] got,
                                 input logic [25:0] want);
        $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_out
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (lamp_q.size() == 0) begin
                note_mismatch("unexpected out beat", o_out_data, '0);
            end else begin
                want = lamp_q.pop_front();
                if (o_out_data.red_level !== want.red_level)
                    note_mismatch("red_level", 26'(o_out_data.red_level),
                                  26'(want.red_level));
                if (o_out_data.green_level !== want.green_level)
                    note_mismatch("green_level", 26'(o_out_data.green_level),
                                  26'(want.green_level));
                if (o_out_data.blue_level !== want.blue_level)
                    note_mismatch("blue_level", 26'(o_out_data.blue_level),
                                  26'(want.blue_level));
                if (o_out_data.rainbow_active !== want.rainbow_active)
                    note_mismatch("rainbow_active", 26'(o_out_data.rainbow_active),
                                  26'(want.rainbow_active));
                if (o_out_data.lamp_off !== want.lamp_off)
                    note_mismatch("lamp_off", 26'(o_out_data.lamp_off),
                                  26'(want.lamp_off));
            end
        end
    end

    // hard stop if the handshake hangs
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
